FILE: hw/rtl/stack_with_search_remove_defines.svh
// ----------------------------------------------------------------------------
// Stack with search and remove: assertion macros
// Shared concurrent assertion forms used by the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_SEARCH_REMOVE_DEFINES_SVH
`define STACK_WITH_SEARCH_REMOVE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("Assertion failed in the same cycle.");

// The consequent must hold in the cycle after the antecedent.
`define SWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("Assertion failed one cycle later.");

`endif

FILE: hw/rtl/sws_pkg.sv
// ----------------------------------------------------------------------------
// Stack with search and remove: package
// Sizes, command and status codes and the result record shared by the RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sws_pkg;

    localparam int DEPTH      = 16;
    localparam int AW         = $clog2(DEPTH);
    localparam int CW         = $clog2(DEPTH + 1);
    localparam int DATA_W     = 32;
    localparam int CMD_W      = 2;
    localparam int POS_W      = 4;
    localparam int COUNT_W    = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    typedef struct packed {
        logic               valid;
        t_status            status;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
    } t_result;

endpackage

FILE: hw/rtl/sws_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/sws_ctrl.sv
// ----------------------------------------------------------------------------
// Stack with search and remove: sequencer
// Walks the entry memory one entry at a time for search and remove, and closes the gap
// after a removal by moving the upper entries down one place each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sws_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [sws_pkg::CMD_W-1:0]         i_command,
    input  logic [sws_pkg::DATA_W-1:0]        i_value,
    output logic                              o_busy,
    output sws_pkg::t_result                  o_res,
    output logic                              o_we,
    output logic [sws_pkg::AW-1:0]            o_waddr,
    output logic [sws_pkg::DATA_W-1:0]        o_wdata,
    output logic [sws_pkg::AW-1:0]            o_raddr,
    input  logic [sws_pkg::DATA_W-1:0]        i_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_SH_RD,
        S_SH_WR
    } t_state;

    t_state                        r_state, n_state;
    logic [sws_pkg::CMD_W-1:0]     r_cmd, n_cmd;
    logic [sws_pkg::DATA_W-1:0]    r_value, n_value;
    logic [sws_pkg::CW-1:0]        r_count, n_count;
    logic [sws_pkg::AW-1:0]        r_idx, n_idx;
    logic [sws_pkg::POS_W-1:0]     r_pos, n_pos;
    logic [sws_pkg::CW-1:0]        idx_w;
    logic [sws_pkg::CW-1:0]        pos_w;

    assign idx_w = sws_pkg::CW'(r_idx);
    assign pos_w = r_count - sws_pkg::CW'(1) - idx_w;

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_value = r_value;
        n_count = r_count;
        n_idx   = r_idx;
        n_pos   = r_pos;
        o_we    = 1'b0;
        o_waddr = r_idx;
        o_wdata = r_value;
        o_raddr = r_idx;
        o_res   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_command;
                    n_value = i_value;
                    case (i_command)
                        sws_pkg::CMD_PUSH: begin
                            if (r_count >= sws_pkg::CW'(sws_pkg::DEPTH)) begin
                                o_res.valid  = 1'b1;
                                o_res.status = sws_pkg::ST_FULL;
                                o_res.count  = sws_pkg::COUNT_W'(r_count);
                            end else begin
                                o_we         = 1'b1;
                                o_waddr      = r_count[sws_pkg::AW-1:0];
                                o_wdata      = i_value;
                                n_count      = r_count + sws_pkg::CW'(1);
                                o_res.valid  = 1'b1;
                                o_res.status = sws_pkg::ST_OK;
                                o_res.count  = sws_pkg::COUNT_W'(n_count);
                            end
                        end
                        sws_pkg::CMD_SEARCH, sws_pkg::CMD_REMOVE: begin
                            if (r_count == '0) begin
                                o_res.valid  = 1'b1;
                                o_res.status = sws_pkg::ST_MISSING;
                                o_res.count  = sws_pkg::COUNT_W'(r_count);
                            end else begin
                                n_idx   = sws_pkg::AW'(r_count - sws_pkg::CW'(1));
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            o_res.valid  = 1'b1;
                            o_res.status = sws_pkg::ST_OK;
                            o_res.count  = sws_pkg::COUNT_W'(r_count);
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_rdata == r_value) begin
                    n_pos = sws_pkg::POS_W'(pos_w);
                    if (r_cmd == sws_pkg::CMD_REMOVE &&
                        (idx_w + sws_pkg::CW'(1)) < r_count) begin
                        n_state = S_SH_RD;
                    end else begin
                        if (r_cmd == sws_pkg::CMD_REMOVE) begin
                            n_count = r_count - sws_pkg::CW'(1);
                        end
                        o_res.valid    = 1'b1;
                        o_res.status   = sws_pkg::ST_OK;
                        o_res.position = sws_pkg::POS_W'(pos_w);
                        o_res.count    = sws_pkg::COUNT_W'(n_count);
                        n_state        = S_IDLE;
                    end
                end else if (r_idx == '0) begin
                    o_res.valid  = 1'b1;
                    o_res.status = sws_pkg::ST_MISSING;
                    o_res.count  = sws_pkg::COUNT_W'(r_count);
                    n_state      = S_IDLE;
                end else begin
                    n_idx   = r_idx - sws_pkg::AW'(1);
                    n_state = S_RD;
                end
            end
            S_SH_RD: begin
                o_raddr = r_idx + sws_pkg::AW'(1);
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                o_we    = 1'b1;
                o_waddr = r_idx;
                o_wdata = i_rdata;
                if ((idx_w + sws_pkg::CW'(2)) < r_count) begin
                    n_idx   = r_idx + sws_pkg::AW'(1);
                    n_state = S_SH_RD;
                end else begin
                    n_count        = r_count - sws_pkg::CW'(1);
                    o_res.valid    = 1'b1;
                    o_res.status   = sws_pkg::ST_OK;
                    o_res.position = r_pos;
                    o_res.count    = sws_pkg::COUNT_W'(n_count);
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_cmd   <= n_cmd;
        r_value <= n_value;
        r_idx   <= n_idx;
        r_pos   <= n_pos;
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: hw/rtl/stack_with_search_remove.sv
// ----------------------------------------------------------------------------
// Stack with search and remove
// Bounded stack of 32-bit values with push, search from the top and removal
// of the match nearest the top.
// ----------------------------------------------------------------------------
// A command transfer is taken at a rising edge where start is high and busy
// is low; i_command selects push, search or remove and i_value carries the
// operand. Every command gives exactly one result, shown for one cycle with
// o_valid high, carrying o_status, o_position and o_count.
// Push and an unused command give their result in the cycle after the transfer.
// Search and remove walk the entry memory from the top, a read state and then
// a compare state for each entry examined, since each compare waits on the
// registered memory read. A removal then moves each entry above the match
// down one place, by a read and then a write. The worst case is removing the
// bottom entry of a full stack: sixteen entries are examined and fifteen moved
// down, and the result shows in the cycle in which busy falls.
// busy stays high while the sequencer walks the memory.
// Reset empties the stack; the entry memory itself is not cleared, and only
// entries below the fill count are ever read.
// The receiver cannot stall: each result must be taken in its cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stack_with_search_remove_defines.svh"

module stack_with_search_remove (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [sws_pkg::CMD_W-1:0]        i_command,
    input  logic signed [sws_pkg::DATA_W-1:0] i_value,
    output logic                             o_valid,
    output logic [1:0]                       o_status,
    output logic [sws_pkg::POS_W-1:0]        o_position,
    output logic [sws_pkg::COUNT_W-1:0]      o_count
);

    sws_pkg::t_result                 res;
    sws_pkg::t_result                 r_res;
    logic                             ram_we;
    logic [sws_pkg::AW-1:0]           ram_waddr;
    logic [sws_pkg::DATA_W-1:0]       ram_wdata;
    logic [sws_pkg::AW-1:0]           ram_raddr;
    logic [sws_pkg::DATA_W-1:0]       ram_rdata;

    sws_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_value   (i_value),
        .o_busy    (busy),
        .o_res     (res),
        .o_we      (ram_we),
        .o_waddr   (ram_waddr),
        .o_wdata   (ram_wdata),
        .o_raddr   (ram_raddr),
        .i_rdata   (ram_rdata)
    );

    sws_ram #(
        .WIDTH (sws_pkg::DATA_W),
        .DEPTH (sws_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else begin
            r_res.valid <= res.valid;
        end
        r_res.status   <= res.status;
        r_res.position <= res.position;
        r_res.count    <= res.count;
    end

    assign o_valid    = r_res.valid;
    assign o_status   = r_res.status;
    assign o_position = r_res.position;
    assign o_count    = r_res.count;

    `SWS_ASSERT_SAME(a_full_at_depth, i_clk, i_rst_n,
        o_valid && o_status == sws_pkg::ST_FULL,
        o_count == sws_pkg::COUNT_W'(sws_pkg::DEPTH))
    `SWS_ASSERT_SAME(a_missing_pos_zero, i_clk, i_rst_n,
        o_valid && o_status == sws_pkg::ST_MISSING,
        o_position == '0)
    `SWS_ASSERT_SAME(a_no_result_on_walk_start, i_clk, i_rst_n,
        $rose(busy),
        !o_valid)
    `SWS_ASSERT_NEXT(a_push_quick, i_clk, i_rst_n,
        start && !busy && i_command == sws_pkg::CMD_PUSH,
        o_valid && !busy)

endmodule
